/* rtl/core/chip8_instruction_core_macros.svh */
// ----------------------------------------------------------------------------
// CHIP-8 instruction core assertion macros
// Concurrent assertion helpers shared by the core's modules.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_MACROS_SVH
`ifndef SYNTHESIS
// The consequent holds in the same cycle as the antecedent.
`define CHIP8_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chip8 assertion failed");
// The consequent holds in the cycle after the antecedent.
`define CHIP8_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chip8 assertion failed");
`else
`define CHIP8_ASSERT_NOW(label, clk, rst, ante, cons)
`define CHIP8_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/chip8_pkg.sv */
// ----------------------------------------------------------------------------
// CHIP-8 core package
// Constants, opcode codes, font table, controller types and helpers.
// ----------------------------------------------------------------------------
package chip8_pkg;

   // Fixed geometry of the machine.
   localparam int MEM_BYTES         = 4096;
   localparam int ADDR_W            = 12;
   localparam int SCREEN_W          = 64;
   localparam int SCREEN_H          = 32;
   localparam int COL_W             = 6;
   localparam int ROW_W             = 5;
   localparam int FONT_BYTES        = 80;
   localparam int STACK_DEPTH_DEF   = 16;
   localparam int NUM_REGS          = 16;
   localparam logic [ADDR_W-1:0] START_ADDR = 12'h200;

   // Request function codes.
   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_EXEC  = 2'd1;
   localparam logic [1:0] FUNC_PIXEL = 2'd2;

   // Opcode groups (top nibble).
   localparam logic [3:0] OPG_SYS      = 4'h0;
   localparam logic [3:0] OPG_JUMP     = 4'h1;
   localparam logic [3:0] OPG_CALL     = 4'h2;
   localparam logic [3:0] OPG_SKIP_EQ  = 4'h3;
   localparam logic [3:0] OPG_SKIP_NE  = 4'h4;
   localparam logic [3:0] OPG_SKIP_REG = 4'h5;
   localparam logic [3:0] OPG_LOAD     = 4'h6;
   localparam logic [3:0] OPG_ADD      = 4'h7;
   localparam logic [3:0] OPG_ALU      = 4'h8;
   localparam logic [3:0] OPG_INDEX    = 4'hA;
   localparam logic [3:0] OPG_DRAW     = 4'hD;
   localparam logic [3:0] OPG_MISC     = 4'hF;

   // ALU sub-codes (low nibble of 8XYN).
   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   localparam logic [15:0] CLS_WORD = 16'h00E0;
   localparam logic [15:0] RET_WORD = 16'h00EE;
   localparam logic [7:0]  BCD_NN   = 8'h33;
   localparam logic [3:0]  FLAG_REG = 4'hF;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   // Controller states.
   typedef enum logic [3:0] {
      ST_SWEEP, ST_IDLE, ST_LOAD, ST_FETCH_HI, ST_FETCH_LO, ST_FETCH_CAP,
      ST_REG_RD, ST_EXEC, ST_WB_X, ST_DRAW_RD, ST_DRAW_UPD, ST_BCD, ST_FINISH
   } ctrl_state_type;

   // Datapath micro-operations.
   typedef enum logic [3:0] {
      OP_NONE, OP_SWEEP, OP_LOAD, OP_FETCH_HI, OP_FETCH_LO, OP_FETCH_CAP,
      OP_EXEC, OP_WB_X, OP_DRAW_RD, OP_DRAW_UPD, OP_DRAW_FIN, OP_BCD, OP_RSP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      req_take;
   } dp_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic is_draw;
      logic is_bcd;
      logic wr_x;
      logic draw_end;
      logic bcd_last;
   } dp_status_type;

   // Reset image of program memory: font at the bottom, zero above.
   function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
      logic [7:0] b;
      b = 8'h00;
      if (a < ADDR_W'(FONT_BYTES)) begin
         b = FONT_ROM[a[6:0]];
      end
      return b;
   endfunction

   // Decimal digits of a byte as {hundreds, tens, ones}.
   function automatic logic [11:0] bcd_digits(input logic [7:0] v);
      logic [1:0]  hund;
      logic [6:0]  rem;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
      rem  = 7'(v - 8'(hund) * 8'd100);
      // Tens by reciprocal: floor(r * 205 / 2048) is exact below 100.
      prod = 15'(rem) * 15'd205;
      tens = prod[14:11];
      ones = rem - 7'(tens) * 7'd10;
      return {2'b00, hund, tens, ones[3:0]};
   endfunction

endpackage

/* rtl/core/chip8_req_if.sv */
// ----------------------------------------------------------------------------
// CHIP-8 request channel
// Valid/ready channel carrying one request to the core.
// ----------------------------------------------------------------------------
interface chip8_req_if;
   import chip8_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic [ADDR_W-1:0] addr;
   logic [7:0]        data;

   modport source (output valid, output func, output addr, output data, input ready);
   modport sink   (input valid, input func, input addr, input data, output ready);
endinterface

/* rtl/core/chip8_rsp_if.sv */
// ----------------------------------------------------------------------------
// CHIP-8 response channel
// Valid/ready channel carrying one response from the core.
// ----------------------------------------------------------------------------
interface chip8_rsp_if;
   import chip8_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] prog_addr;
   logic [15:0]       fetched_word;
   logic              illegal;
   logic              redraw;
   logic              pixel_value;

   modport source (output valid, output prog_addr, output fetched_word, output illegal,
                   output redraw, output pixel_value, input ready);
   modport sink   (input valid, input prog_addr, input fetched_word, input illegal,
                   input redraw, input pixel_value, output ready);
endinterface

/* rtl/core/chip8_dp.sv */
// ----------------------------------------------------------------------------
// CHIP-8 datapath
// Program memory, register file, stack, frame buffer and execute logic,
// stepped by micro-operations from the controller.
// ----------------------------------------------------------------------------
`include "chip8_instruction_core_macros.svh"

module chip8_dp #(
   parameter int STACK_DEPTH = chip8_pkg::STACK_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  chip8_pkg::dp_cmd_type        cmd,
   output chip8_pkg::dp_status_type     status,
   input  logic [1:0]                   req_func,
   input  logic [chip8_pkg::ADDR_W-1:0] req_addr,
   input  logic [7:0]                   req_data,
   output logic [chip8_pkg::ADDR_W-1:0] rsp_prog_addr,
   output logic [15:0]                  rsp_fetched_word,
   output logic                         rsp_illegal,
   output logic                         rsp_redraw,
   output logic                         rsp_pixel_value
);
   import chip8_pkg::*;

   localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // Memories.
   logic [7:0]        mem [MEM_BYTES];
   logic [7:0]        mem_q_ff;
   logic [7:0]        rf [NUM_REGS];
   logic [NUM_REGS-1:0] rf_valid_ff;
   logic [SCREEN_W-1:0] frame_ff [SCREEN_H];
   logic [ADDR_W-1:0] stack_ff [STACK_DEPTH];

   // Architectural and working registers.
   logic [ADDR_W-1:0] sweep_cnt_ff;
   logic [1:0]        func_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [7:0]        data_ff;
   logic [ADDR_W-1:0] pc_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic [SP_W-1:0]   sp_ff;
   logic              pending_ff;
   logic [7:0]        hi_ff;
   logic [15:0]       ir_ff;
   logic [7:0]        vx_ff;
   logic [7:0]        vy_ff;
   logic [7:0]        res_ff;
   logic              hit_ff;
   logic [COL_W-1:0]  x0_ff;
   logic [ROW_W-1:0]  y0_ff;
   logic [3:0]        row_ff;
   logic [1:0]        bcd_cnt_ff;

   logic [3:0]  grp;
   logic [3:0]  lo4;
   logic [7:0]  nn;
   logic [3:0]  x_sel;
   logic [3:0]  y_sel;
   logic [SP_W-1:0] sp_inc;
   logic [SP_W-1:0] sp_dec;
   logic [8:0]  sum9;

   logic              ex_legal;
   logic [ADDR_W-1:0] ex_next_pc;
   logic              ex_flag_we;
   logic              ex_flag;
   logic [7:0]        ex_res;
   logic              ex_wr_x;
   logic              ex_push;
   logic              ex_pop;
   logic              ex_idx_we;
   logic              ex_clear;
   logic              ex_draw;
   logic              ex_bcd;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [7:0]        mem_wd;
   logic [ADDR_W-1:0] mem_ra;
   logic              rf_we;
   logic [3:0]        rf_wa;
   logic [7:0]        rf_wd;

   logic [ROW_W:0]    draw_y;
   logic [ROW_W-1:0]  row_sel;
   logic [SCREEN_W-1:0] frame_row;
   logic [7:0]        sprite_rev;
   logic [SCREEN_W-1:0] sprite_mask;
   logic [11:0]       digits;
   logic [7:0]        bcd_byte;

   assign grp   = ir_ff[15:12];
   assign lo4   = ir_ff[3:0];
   assign nn    = ir_ff[7:0];
   assign x_sel = ir_ff[11:8];
   assign y_sel = ir_ff[7:4];

   assign sp_inc = (sp_ff == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
   assign sp_dec = (sp_ff == '0) ? SP_W'(STACK_DEPTH - 1) : sp_ff - 1'b1;
   assign sum9   = {1'b0, vx_ff} + {1'b0, vy_ff};

   // Instruction decode and execute results.
   always_comb begin
      ex_legal   = 1'b1;
      ex_next_pc = pc_ff + 12'd2;
      ex_flag_we = 1'b0;
      ex_flag    = 1'b0;
      ex_res     = vx_ff;
      ex_wr_x    = 1'b0;
      ex_push    = 1'b0;
      ex_pop     = 1'b0;
      ex_idx_we  = 1'b0;
      ex_clear   = 1'b0;
      ex_draw    = 1'b0;
      ex_bcd     = 1'b0;
      case (grp)
         OPG_SYS: begin
            if (ir_ff == CLS_WORD) begin
               ex_clear = 1'b1;
            end else if (ir_ff == RET_WORD) begin
               ex_pop     = 1'b1;
               ex_next_pc = stack_ff[sp_dec] + 12'd2;
            end else begin
               ex_legal = 1'b0;
            end
         end
         OPG_JUMP: ex_next_pc = ir_ff[11:0];
         OPG_CALL: begin
            ex_push    = 1'b1;
            ex_next_pc = ir_ff[11:0];
         end
         OPG_SKIP_EQ: begin
            if (vx_ff == nn) ex_next_pc = pc_ff + 12'd4;
         end
         OPG_SKIP_NE: begin
            if (vx_ff != nn) ex_next_pc = pc_ff + 12'd4;
         end
         OPG_SKIP_REG: begin
            if (lo4 != ALU_MOV) begin
               ex_legal = 1'b0;
            end else if (vx_ff == vy_ff) begin
               ex_next_pc = pc_ff + 12'd4;
            end
         end
         OPG_LOAD: begin
            ex_wr_x = 1'b1;
            ex_res  = nn;
         end
         OPG_ADD: begin
            ex_wr_x = 1'b1;
            ex_res  = vx_ff + nn;
         end
         OPG_ALU: begin
            case (lo4)
               ALU_MOV: begin ex_wr_x = 1'b1; ex_res = vy_ff; end
               ALU_OR:  begin ex_wr_x = 1'b1; ex_res = vx_ff | vy_ff; end
               ALU_AND: begin ex_wr_x = 1'b1; ex_res = vx_ff & vy_ff; end
               ALU_XOR: begin ex_wr_x = 1'b1; ex_res = vx_ff ^ vy_ff; end
               ALU_ADD: begin
                  ex_wr_x = 1'b1; ex_flag_we = 1'b1;
                  ex_flag = sum9[8]; ex_res = sum9[7:0];
               end
               ALU_SUB: begin
                  ex_wr_x = 1'b1; ex_flag_we = 1'b1;
                  ex_flag = !(vy_ff > vx_ff); ex_res = vx_ff - vy_ff;
               end
               ALU_SHR: begin
                  ex_wr_x = 1'b1; ex_flag_we = 1'b1;
                  ex_flag = vx_ff[0]; ex_res = {1'b0, vx_ff[7:1]};
               end
               ALU_SUBN: begin
                  ex_wr_x = 1'b1; ex_flag_we = 1'b1;
                  ex_flag = !(vx_ff > vy_ff); ex_res = vy_ff - vx_ff;
               end
               ALU_SHL: begin
                  ex_wr_x = 1'b1; ex_flag_we = 1'b1;
                  ex_flag = vx_ff[7]; ex_res = {vx_ff[6:0], 1'b0};
               end
               default: ex_legal = 1'b0;
            endcase
         end
         OPG_INDEX: ex_idx_we = 1'b1;
         OPG_DRAW:  ex_draw = 1'b1;
         OPG_MISC: begin
            if (nn == BCD_NN) ex_bcd = 1'b1;
            else ex_legal = 1'b0;
         end
         default: ex_legal = 1'b0;
      endcase
   end

   // Sprite row geometry; one frame row is addressed at a time.
   assign draw_y  = {1'b0, y0_ff} + (ROW_W + 1)'(row_ff);
   assign row_sel = (cmd.op == OP_DRAW_UPD) ? draw_y[ROW_W-1:0] : addr_ff[COL_W+ROW_W-1:COL_W];
   assign frame_row = frame_ff[row_sel];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         sprite_rev[i] = mem_q_ff[7-i];
      end
   end
   assign sprite_mask = SCREEN_W'(sprite_rev) << x0_ff;

   assign digits = bcd_digits(vx_ff);
   always_comb begin
      case (bcd_cnt_ff)
         2'd0:    bcd_byte = {4'h0, digits[11:8]};
         2'd1:    bcd_byte = {4'h0, digits[7:4]};
         default: bcd_byte = {4'h0, digits[3:0]};
      endcase
   end

   assign status.sweep_last = (sweep_cnt_ff == ADDR_W'(MEM_BYTES - 1));
   assign status.is_draw    = ex_draw;
   assign status.is_bcd     = ex_bcd;
   assign status.wr_x       = ex_wr_x;
   assign status.draw_end   = (row_ff == lo4) || draw_y[ROW_W];
   assign status.bcd_last   = (bcd_cnt_ff == 2'd2);

   // Program memory port selection.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = data_ff;
      case (cmd.op)
         OP_SWEEP: begin
            mem_we = 1'b1; mem_wa = sweep_cnt_ff; mem_wd = font_byte(sweep_cnt_ff);
         end
         OP_LOAD: mem_we = 1'b1;
         OP_BCD: begin
            mem_we = 1'b1; mem_wa = idx_ff + 12'(bcd_cnt_ff); mem_wd = bcd_byte;
         end
         default: mem_we = 1'b0;
      endcase
      case (cmd.op)
         OP_FETCH_HI: mem_ra = pc_ff;
         OP_FETCH_LO: mem_ra = pc_ff + 12'd1;
         default:     mem_ra = idx_ff + 12'(row_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[mem_ra];
   end

   // Register file write port selection.
   always_comb begin
      rf_we = 1'b0;
      rf_wa = FLAG_REG;
      rf_wd = {7'b0, ex_flag};
      case (cmd.op)
         OP_EXEC: rf_we = ex_legal && ex_flag_we;
         OP_WB_X: begin
            rf_we = 1'b1; rf_wa = x_sel; rf_wd = res_ff;
         end
         OP_DRAW_FIN: begin
            rf_we = 1'b1; rf_wd = {7'b0, hit_ff};
         end
         default: rf_we = 1'b0;
      endcase
   end

   // Register file: entries read as zero until first written.
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf[rf_wa] <= rf_wd;
      end
      vx_ff <= rf_valid_ff[x_sel] ? rf[x_sel] : 8'h00;
      vy_ff <= rf_valid_ff[y_sel] ? rf[y_sel] : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (rf_we) begin
         rf_valid_ff[rf_wa] <= 1'b1;
      end
   end

   // Request capture and instruction staging.
   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         func_ff <= req_func;
         addr_ff <= req_addr;
         data_ff <= req_data;
      end
      if (cmd.op == OP_FETCH_LO)  hi_ff <= mem_q_ff;
      if (cmd.op == OP_FETCH_CAP) ir_ff <= {hi_ff, mem_q_ff};
      if (cmd.op == OP_EXEC) begin
         res_ff <= ex_res;
         x0_ff  <= vx_ff[COL_W-1:0];
         y0_ff  <= vy_ff[ROW_W-1:0];
      end
   end

   // Architectural state, sequencing counters and frame buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
         pc_ff        <= START_ADDR;
         idx_ff       <= '0;
         sp_ff        <= '0;
         pending_ff   <= 1'b1;
         hit_ff       <= 1'b0;
         row_ff       <= '0;
         bcd_cnt_ff   <= '0;
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= '0;
         for (int r = 0; r < SCREEN_H; r++) frame_ff[r] <= '0;
      end else begin
         case (cmd.op)
            OP_SWEEP: sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
            OP_EXEC: begin
               hit_ff     <= 1'b0;
               row_ff     <= '0;
               bcd_cnt_ff <= '0;
               if (ex_legal) pc_ff <= ex_next_pc;
               if (ex_idx_we) idx_ff <= ir_ff[11:0];
               if (ex_push) begin
                  stack_ff[sp_ff] <= pc_ff;
                  sp_ff <= sp_inc;
               end
               if (ex_pop) sp_ff <= sp_dec;
               if (ex_clear) begin
                  for (int r = 0; r < SCREEN_H; r++) frame_ff[r] <= '0;
               end
            end
            OP_DRAW_UPD: begin
               frame_ff[row_sel] <= frame_row ^ sprite_mask;
               hit_ff <= hit_ff | (|(frame_row & sprite_mask));
               row_ff <= row_ff + 1'b1;
            end
            OP_DRAW_FIN: pending_ff <= 1'b1;
            // The digit counter returns to zero after the ones digit.
            OP_BCD:      bcd_cnt_ff <= (bcd_cnt_ff == 2'd2) ? 2'd0 : bcd_cnt_ff + 1'b1;
            OP_RSP_LOAD: begin
               if (func_ff == FUNC_EXEC) pending_ff <= 1'b0;
            end
            default: pending_ff <= pending_ff;
         endcase
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_RSP_LOAD) begin
         rsp_prog_addr    <= pc_ff;
         rsp_fetched_word <= (func_ff == FUNC_EXEC) ? ir_ff : 16'h0000;
         rsp_illegal      <= (func_ff == FUNC_EXEC) && !ex_legal;
         rsp_redraw       <= (func_ff == FUNC_EXEC) && pending_ff;
         rsp_pixel_value  <= (func_ff == FUNC_PIXEL) && !addr_ff[ADDR_W-1]
                             && frame_row[addr_ff[COL_W-1:0]];
      end
   end

   `CHIP8_ASSERT_NOW(a_bcd_cnt_range, clock, reset, 1'b1, bcd_cnt_ff != 2'd3)
   `CHIP8_ASSERT_NOW(a_draw_rows, clock, reset, cmd.op == OP_DRAW_UPD, !draw_y[ROW_W])
   `CHIP8_ASSERT_NOW(a_draw_row_limit, clock, reset, cmd.op == OP_DRAW_UPD, row_ff != lo4)

endmodule

/* rtl/core/chip8_ctrl.sv */
// ----------------------------------------------------------------------------
// CHIP-8 controller
// Sequences the datapath through sweep, load, fetch, execute, draw, BCD and response steps.
// ----------------------------------------------------------------------------
`include "chip8_instruction_core_macros.svh"

module chip8_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_func,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  chip8_pkg::dp_status_type status,
   output chip8_pkg::dp_cmd_type    cmd
);
   import chip8_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.req_take = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            cmd.op = OP_SWEEP;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_take = 1'b1;
               case (req_func)
                  FUNC_LOAD: state_in = ST_LOAD;
                  FUNC_EXEC: state_in = ST_FETCH_HI;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.op   = OP_LOAD;
            state_in = ST_FINISH;
         end
         ST_FETCH_HI: begin
            cmd.op   = OP_FETCH_HI;
            state_in = ST_FETCH_LO;
         end
         ST_FETCH_LO: begin
            cmd.op   = OP_FETCH_LO;
            state_in = ST_FETCH_CAP;
         end
         ST_FETCH_CAP: begin
            cmd.op   = OP_FETCH_CAP;
            state_in = ST_REG_RD;
         end
         ST_REG_RD: state_in = ST_EXEC;
         ST_EXEC: begin
            cmd.op = OP_EXEC;
            if (status.is_draw)     state_in = ST_DRAW_RD;
            else if (status.is_bcd) state_in = ST_BCD;
            else if (status.wr_x)   state_in = ST_WB_X;
            else                    state_in = ST_FINISH;
         end
         ST_WB_X: begin
            cmd.op   = OP_WB_X;
            state_in = ST_FINISH;
         end
         ST_DRAW_RD: begin
            if (status.draw_end) begin
               cmd.op   = OP_DRAW_FIN;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_DRAW_RD;
               state_in = ST_DRAW_UPD;
            end
         end
         ST_DRAW_UPD: begin
            cmd.op   = OP_DRAW_UPD;
            state_in = ST_DRAW_RD;
         end
         ST_BCD: begin
            cmd.op = OP_BCD;
            if (status.bcd_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = OP_RSP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Response valid: set on load, dropped when taken.
   always_comb begin
      if (cmd.op == OP_RSP_LOAD) rsp_valid_in = 1'b1;
      else if (rsp_ready)        rsp_valid_in = 1'b0;
      else                       rsp_valid_in = rsp_valid_ff;
   end
   assign rsp_valid = rsp_valid_ff;

   `CHIP8_ASSERT_NOW(a_rsp_slot_free, clock, reset, cmd.op == OP_RSP_LOAD, !rsp_valid_ff || rsp_ready)
   `CHIP8_ASSERT_NEXT(a_rsp_after_load, clock, reset, cmd.op == OP_RSP_LOAD, rsp_valid_ff)
   `CHIP8_ASSERT_NEXT(a_busy_after_take, clock, reset, cmd.req_take, state_ff != ST_IDLE)

endmodule

/* rtl/core/chip8_instruction_core.sv */
// ----------------------------------------------------------------------------
// CHIP-8 instruction core
// Loads program bytes, executes one instruction per request, reads pixels.
//
//   Channel  Direction  Fields
//   req_bus  in         func, addr, data
//   rsp_bus  out        prog_addr, fetched_word, illegal, redraw, pixel_value
//
// A load adds a memory write step before the response. An execute fetches
// both bytes, captures the word, reads registers, executes, writes back any
// result; a sprite draw adds a read and an update step per drawn row plus a
// closing step, and BCD store adds a step per digit. Program memory reads
// one byte a cycle with registered data. After reset a pass writes the font
// and zeros into all of program memory; no request is accepted until it
// ends. A waiting response stalls the next request only at its final step.
// ----------------------------------------------------------------------------
module chip8_instruction_core #(
   parameter int STACK_DEPTH = chip8_pkg::STACK_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   chip8_req_if.sink    req_bus,
   chip8_rsp_if.source  rsp_bus
);
   import chip8_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Controller.
   chip8_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_func  (req_bus.func),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   chip8_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_bus.func),
      .req_addr         (req_bus.addr),
      .req_data         (req_bus.data),
      .rsp_prog_addr    (rsp_bus.prog_addr),
      .rsp_fetched_word (rsp_bus.fetched_word),
      .rsp_illegal      (rsp_bus.illegal),
      .rsp_redraw       (rsp_bus.redraw),
      .rsp_pixel_value  (rsp_bus.pixel_value)
   );

endmodule
